[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising edge outside reset
`define CLNW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that cond never holds outside reset
`define CLNW_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/clnw_pkg.sv]
`default_nettype none
package clnw_pkg;

  localparam int unsigned STEP_W = 3;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] INIT_LAST = 3'd5;

  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_CHAR = 2'd2;
  localparam logic [1:0] REQ_POS  = 2'd3;

  localparam logic CFG_SETUP_HOLD  = 1'b0;
  localparam logic CFG_PULSE_WIDTH = 1'b1;

  localparam logic [15:0] HOLD_RESET = 16'd500;

  localparam logic [7:0] DDRAM_SET = 8'h80;
  localparam logic [7:0] FUNC_SET  = 8'h20;
  localparam logic [7:0] DISP_CTRL = 8'h08;
  localparam logic [7:0] ENTRY_SET = 8'h04;
  localparam logic [7:0] CLEAR_CMD = 8'h01;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] value;
    logic [4:0] column;
    logic [1:0] row;
  } in_word_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable;
    logic [3:0]  data_nibble;
    logic [15:0] hold_us;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic              half;
    logic              en;
    logic              hold_pulse;
    logic              end_byte;
    logic [STEP_W-1:0] jump;
  } ucode_t;

  typedef struct packed {
    logic             fire;
    logic             half;
    logic             en;
    logic             hold_pulse;
    logic             last;
    logic             init;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uw;
    uw = '{half: 1'b0, en: 1'b0, hold_pulse: 1'b0, end_byte: 1'b1, jump: '0};
    unique case (step)
      3'd0: uw = '{half: 1'b0, en: 1'b0, hold_pulse: 1'b0, end_byte: 1'b0, jump: '0};
      3'd1: uw = '{half: 1'b0, en: 1'b1, hold_pulse: 1'b1, end_byte: 1'b0, jump: '0};
      3'd2: uw = '{half: 1'b0, en: 1'b0, hold_pulse: 1'b0, end_byte: 1'b0, jump: '0};
      3'd3: uw = '{half: 1'b1, en: 1'b0, hold_pulse: 1'b0, end_byte: 1'b0, jump: '0};
      3'd4: uw = '{half: 1'b1, en: 1'b1, hold_pulse: 1'b1, end_byte: 1'b0, jump: '0};
      3'd5: uw = '{half: 1'b1, en: 1'b0, hold_pulse: 1'b0, end_byte: 1'b1, jump: '0};
      default: uw = '{half: 1'b1, en: 1'b0, hold_pulse: 1'b0, end_byte: 1'b1, jump: '0};
    endcase
    return uw;
  endfunction

  function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = CLEAR_CMD;
    unique case (idx)
      3'd0: b = FUNC_SET | 8'h13;
      3'd1: b = FUNC_SET | 8'h12;
      3'd2: b = FUNC_SET | 8'h08;
      3'd3: b = DISP_CTRL | 8'h04;
      3'd4: b = ENTRY_SET | 8'h02;
      default: b = CLEAR_CMD;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] line_start(input logic [1:0] row);
    logic [7:0] s;
    unique case (row)
      2'd0: s = 8'h00;
      2'd1: s = 8'h40;
      2'd2: s = 8'h14;
      default: s = 8'h54;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[sv/clnw_seq.sv]
`default_nettype none
module clnw_seq import clnw_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     init_i,
  input  wire logic     out_ready_i,
  output logic          busy_o,
  output ctrl_t         ctrl_o
);

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              init_q, init_d;
  ucode_t            uw;
  logic              more;
  logic              fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      init_q  <= init_d;
    end
  end

  always_comb begin
    uw      = ucode_rom(step_q);
    more    = init_q && (idx_q != INIT_LAST);
    fire    = 1'b0;
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    init_d  = init_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = SEQ_RUN;
          step_d  = '0;
          idx_d   = '0;
          init_d  = init_i;
        end
      end
      SEQ_RUN: begin
        if (out_ready_i) begin
          fire = 1'b1;
          if (uw.end_byte) begin
            if (more) begin
              idx_d  = idx_q + 1'b1;
              step_d = uw.jump;
            end else begin
              state_d = SEQ_IDLE;
            end
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  assign busy_o            = (state_q != SEQ_IDLE);
  assign ctrl_o.fire       = fire;
  assign ctrl_o.half       = uw.half;
  assign ctrl_o.en         = uw.en;
  assign ctrl_o.hold_pulse = uw.hold_pulse;
  assign ctrl_o.last       = uw.end_byte && !more;
  assign ctrl_o.init       = init_q;
  assign ctrl_o.idx        = idx_q;

endmodule
`default_nettype wire

[sv/clnw_dp.sv]
`default_nettype none
module clnw_dp import clnw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        start_i,
  input  wire in_word_t    in_word_i,
  input  wire ctrl_t       ctrl_i,
  input  wire logic        out_stall_i,
  output logic             out_ready_o,
  output logic             out_valid_o,
  output out_word_t        out_word_o
);

  logic [15:0] setup_q, pulse_q;
  logic [7:0]  byte_q, byte_d;
  logic        rs_q;
  logic        valid_q;
  out_word_t   out_q;
  logic [7:0]  cur_byte;
  logic [3:0]  nib;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= HOLD_RESET;
      pulse_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SETUP_HOLD) begin
        setup_q <= cfg_data_i;
      end else begin
        pulse_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    case (in_word_i.req_type)
      REQ_POS: byte_d = DDRAM_SET + line_start(in_word_i.row) + {3'b000, in_word_i.column};
      default: byte_d = in_word_i.value;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      byte_q <= byte_d;
      rs_q   <= (in_word_i.req_type == REQ_CHAR);
    end
  end

  assign cur_byte = ctrl_i.init ? init_byte(ctrl_i.idx) : byte_q;
  assign nib      = ctrl_i.half ? cur_byte[3:0] : cur_byte[7:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.fire) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      out_q.reg_select  <= rs_q && !ctrl_i.init;
      out_q.enable      <= ctrl_i.en;
      out_q.data_nibble <= nib;
      out_q.hold_us     <= ctrl_i.hold_pulse ? pulse_q : setup_q;
      out_q.last        <= ctrl_i.last;
    end
  end

  assign out_ready_o = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

[sv/char_lcd_nibble_writer_top.sv]
// Character LCD writer for a 4-bit bus. Each request word becomes a run of pin-event
// words (data set, enable high, enable low per nibble, high nibble first), one per
// clock while the output is not stalled, from a six-step microprogram. A command,
// character or position request is loaded at its accept and then issues six event
// words, an init request the events of six bytes; a stalled event word holds the
// sequence until the output takes it. A new request is accepted the cycle after the
// last event of the previous one enters the output register. Hold times come from two
// registers written via the cfg port, by the user only while idle; not enforced here.
`default_nettype none
`include "assert_macros.svh"
module char_lcd_nibble_writer_top import clnw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o
);

  logic  busy;
  logic  start;
  logic  out_ready;
  ctrl_t ctrl;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  clnw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .init_i      (in_word_i.req_type == REQ_INIT),
    .out_ready_i (out_ready),
    .busy_o      (busy),
    .ctrl_o      (ctrl)
  );

  clnw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start),
    .in_word_i   (in_word_i),
    .ctrl_i      (ctrl),
    .out_stall_i (out_stall_i),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  `CLNW_ASSERT(a_last_frees, clk_i, rst_ni, ctrl.fire && ctrl.last |=> !in_stall_o, "busy after last event")
  `CLNW_ASSERT(a_fire_shows, clk_i, rst_ni, ctrl.fire |=> out_valid_o && (out_word_o.last == $past(ctrl.last)), "event word lost")
  `CLNW_NEVER(a_idle_quiet, clk_i, rst_ni, !in_stall_o && ctrl.fire, "event while idle")

endmodule
`default_nettype wire

[tb/char_lcd_event_checker.sv]
`timescale 1ns / 100ps
module char_lcd_event_checker import clnw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int          mismatch_cnt_o,
  output int          pending_o,
  output int          events_seen_o
);

  localparam logic [47:0] POWER_UP_SEQ = 48'h33_32_28_0C_06_01;
  localparam logic [31:0] ROW_BASE     = 32'h00_40_14_54;

  logic [15:0] setup_hold;
  logic [15:0] pulse_width;
  out_word_t   lcd_events_q[$];
  out_word_t   want_ev;

  task automatic push_event(input logic rs, input logic en, input logic [3:0] nib,
                            input logic [15:0] hold, input logic fin);
    out_word_t ev;
    ev.reg_select  = rs;
    ev.enable      = en;
    ev.data_nibble = nib;
    ev.hold_us     = hold;
    ev.last        = fin;
    lcd_events_q.push_back(ev);
  endtask

  // high nibble first; each nibble is data set, enable high, enable low
  task automatic queue_byte_events(input logic [7:0] b, input logic rs, input logic fin);
    logic [3:0] nib;
    for (int h = 0; h < 2; h++) begin
      nib = (h == 0) ? b[7:4] : b[3:0];
      push_event(rs, 1'b0, nib, setup_hold, 1'b0);
      push_event(rs, 1'b1, nib, pulse_width, 1'b0);
      push_event(rs, 1'b0, nib, setup_hold, fin && (h == 1));
    end
  endtask

  task automatic predict_request(input in_word_t w);
    logic [7:0] addr;
    case (w.req_type)
      REQ_INIT: begin
        for (int i = 0; i < 6; i++) begin
          queue_byte_events(POWER_UP_SEQ[47-8*i -: 8], 1'b0, i == 5);
        end
      end
      REQ_CMD: begin
        queue_byte_events(w.value, 1'b0, 1'b1);
      end
      REQ_CHAR: begin
        queue_byte_events(w.value, 1'b1, 1'b1);
      end
      default: begin
        addr = DDRAM_SET | (ROW_BASE[31-8*w.row -: 8] + {3'b000, w.column});
        queue_byte_events(addr, 1'b0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatch_cnt_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_hold     = HOLD_RESET;
      pulse_width    = HOLD_RESET;
      lcd_events_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
      events_seen_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SETUP_HOLD) begin
          setup_hold = cfg_data_i;
        end else begin
          pulse_width = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request(in_word_i);
      end
      if (out_valid_i && !out_stall_i) begin
        events_seen_o++;
        if (lcd_events_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: unexpected word, expected none, got %0h", $time, out_word_i);
        end else begin
          want_ev = lcd_events_q.pop_front();
          check_field("reg_select", 16'(want_ev.reg_select), 16'(out_word_i.reg_select));
          check_field("enable", 16'(want_ev.enable), 16'(out_word_i.enable));
          check_field("data_nibble", 16'(want_ev.data_nibble),
                      16'(out_word_i.data_nibble));
          check_field("hold_us", want_ev.hold_us, out_word_i.hold_us);
          check_field("last", 16'(want_ev.last), 16'(out_word_i.last));
        end
      end
      pending_o = lcd_events_q.size();
    end
  end

endmodule

[tb/tb_char_lcd_nibble_writer_top.sv]
`timescale 1ns / 100ps
module tb_char_lcd_nibble_writer_top;
  import clnw_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 160;
  localparam int SETTLE_CYCLES  = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  int mismatch_cnt;
  int pending;
  int events_seen;
  int cycle_cnt = 0;
  int words_sent = 0;
  int settings_cnt = 1;
  int type_cnt [4];
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit holdoff_req = 1'b0;

  char_lcd_nibble_writer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  char_lcd_event_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_word_i      (in_word),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_word_i     (out_word),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .events_seen_o  (events_seen)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d words outstanding", $time, cycle_cnt,
               pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        hold_left   = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= rx_gaps && ($urandom_range(99) < 23);
      end
    end
  end

  function automatic in_word_t request_word(input logic [1:0] kind, input logic [7:0] val,
                                            input logic [4:0] col, input logic [1:0] row);
    in_word_t w;
    w.req_type = kind;
    w.value    = val;
    w.column   = col;
    w.row      = row;
    return w;
  endfunction

  function automatic in_word_t rand_request();
    in_word_t w;
    w.value = 8'($urandom_range(255));
    w.row   = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) begin
      w.column = 5'($urandom_range(31));
    end else begin
      w.column = 5'($urandom_range(19));
    end
    if ($urandom_range(99) < 8) begin
      w.req_type = REQ_INIT;
    end else begin
      w.req_type = 2'($urandom_range(3, 1));
    end
    return w;
  endfunction

  // enter and leave at a falling edge
  task automatic send_word(input in_word_t w);
    while (tx_gaps && ($urandom_range(99) < 23)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    type_cnt[w.req_type]++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    foreach (type_cnt[k]) type_cnt[k] = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(request_word(REQ_INIT, 8'h00, 5'd0, 2'd0));
    send_word(request_word(REQ_CMD, 8'h00, 5'd31, 2'd3));
    send_word(request_word(REQ_CMD, 8'hFF, 5'd0, 2'd0));
    send_word(request_word(REQ_CHAR, 8'h00, 5'd31, 2'd3));
    send_word(request_word(REQ_CHAR, 8'hFF, 5'd0, 2'd0));
    send_word(request_word(REQ_CHAR, 8'h5A, 5'd10, 2'd1));
    send_word(request_word(REQ_POS, 8'hFF, 5'd0, 2'd0));
    send_word(request_word(REQ_POS, 8'h00, 5'd19, 2'd1));
    send_word(request_word(REQ_POS, 8'hA5, 5'd19, 2'd2));
    send_word(request_word(REQ_POS, 8'h00, 5'd19, 2'd3));
    send_word(request_word(REQ_POS, 8'h00, 5'd20, 2'd0));
    send_word(request_word(REQ_POS, 8'h00, 5'd31, 2'd3));
    send_word(request_word(REQ_INIT, 8'hFF, 5'd31, 2'd3));

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(CFG_SETUP_HOLD, 16'h0000);
          write_reg(CFG_PULSE_WIDTH, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_SETUP_HOLD, 16'hFFFF);
          write_reg(CFG_PULSE_WIDTH, 16'h0001);
        end
        2: begin
          write_reg(CFG_SETUP_HOLD, 16'h0001);
          write_reg(CFG_PULSE_WIDTH, 16'h0000);
        end
        default: begin
          write_reg(CFG_SETUP_HOLD, 16'($urandom_range(65535)));
          write_reg(CFG_PULSE_WIDTH, 16'($urandom_range(65535)));
        end
      endcase
      // hold the receiver off while requests keep coming
      if (p == 0) holdoff_req = 1'b1;
      tx_gaps = (p != 1);
      rx_gaps = (p != 1);
      for (int i = 0; i < 67; i++) begin
        send_word(rand_request());
        if (p == 2 && i == 33) drain();
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    drain();

    if (pending != 0) begin
      $display("%0t: %0d expected words never arrived, got none", $time, pending);
    end
    $display("Covered %0d requests: %0d init, %0d command, %0d character, %0d position",
             words_sent, type_cnt[0], type_cnt[1], type_cnt[2], type_cnt[3]);
    $display("Compared %0d pin-event words under %0d hold-time settings",
             events_seen, settings_cnt);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
